>>> sv/bmpdec_pkg.sv
`default_nettype none
package bmpdec_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	// clamped dimensions hold up to MAX + 1 to mark an oversized image
	localparam int DIM_W = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 2);
	localparam int COORD_W = 12;

	localparam logic [31:0] MIN_HEADER_SIZE = 32'd40;
	localparam logic [15:0] PIXEL_BITS      = 16'd24;
	localparam logic [31:0] MIN_PIXEL_START = 32'd30;

	// header byte positions at which a field is complete
	localparam logic [31:0] POS_DATA_OFFSET = 32'd13;
	localparam logic [31:0] POS_HDR_SIZE    = 32'd17;
	localparam logic [31:0] POS_WIDTH       = 32'd21;
	localparam logic [31:0] POS_HEIGHT      = 32'd25;
	localparam logic [31:0] POS_PLANES      = 32'd27;
	localparam logic [31:0] POS_BPP         = 32'd29;

	typedef enum logic [2:0] {
		ST_PIXEL      = 3'd0,
		ST_HDR_SMALL  = 3'd1,
		ST_BAD_PLANES = 3'd2,
		ST_BAD_BPP    = 3'd3,
		ST_ZERO_HGT   = 3'd4,
		ST_TOO_LARGE  = 3'd5,
		ST_BAD_OFFSET = 3'd6
	} status_t;

	typedef struct packed {
		status_t              status;
		logic [7:0]           red;
		logic [7:0]           green;
		logic [7:0]           blue;
		logic [COORD_W-1:0]   column;
		logic [COORD_W-1:0]   row;
		logic                 last_pixel;
	} result_t;

endpackage
`default_nettype wire

>>> sv/bmp_bgr24_stream_decoder_top.sv
`default_nettype none
// Streaming decoder for 24-bit BMP files. One file byte is taken per word on the
// input channel, with first_byte set on byte zero to restart parsing (parsing
// also starts fresh after reset). The header is checked as it passes; the first
// failed check yields one error word and later bytes are dropped until the next
// restart. Pixel bytes (after the data offset, with row padding removed) yield
// one RGB word per three bytes, with column and top-to-bottom row. The block
// takes one byte per clock: each byte goes through an input register, then the
// field and counter logic, into a two-word output queue. The input
// stalls when the queued words and the byte in the input register add up to two
// and no word leaves in that cycle.
module bmp_bgr24_stream_decoder_top
	import bmpdec_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         file_byte,
	input  wire logic               first_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [7:0]              red,
	output logic [7:0]              green,
	output logic [7:0]              blue,
	output logic [COORD_W-1:0]      column,
	output logic [COORD_W-1:0]      row,
	output logic                    last_pixel
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXELS,
		PH_DONE
	} phase_t;

	// input register
	logic       valid_s1;
	logic [7:0] file_byte_s1;
	logic       first_byte_s1;

	// parser state
	logic [31:0]        byte_offset_q;
	logic [31:0]        field_q;
	logic [31:0]        data_start_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic               bottom_up_q;
	logic [COORD_W-1:0] col_cnt_q;
	logic [COORD_W-1:0] row_cnt_q;
	logic [1:0]         pad_left_q;
	logic [1:0]         chan_q;
	logic [15:0]        bg_q;
	phase_t             phase_q;

	// next state
	logic [31:0]        byte_offset_d;
	logic [31:0]        field_d;
	logic [31:0]        data_start_d;
	logic [DIM_W-1:0]   width_d;
	logic [DIM_W-1:0]   height_d;
	logic               bottom_up_d;
	logic [COORD_W-1:0] col_cnt_d;
	logic [COORD_W-1:0] row_cnt_d;
	logic [1:0]         pad_left_d;
	logic [1:0]         chan_d;
	logic [15:0]        bg_d;
	phase_t             phase_d;

	logic    emit;
	result_t res;

	// output queue
	result_t     entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;
	logic [1:0]  occ;

	localparam logic [DIM_W-1:0] WIDTH_OVER  = DIM_W'(MAX_WIDTH + 1);
	localparam logic [DIM_W-1:0] HEIGHT_OVER = DIM_W'(MAX_HEIGHT + 1);

	always_comb begin
		logic [31:0]      v;
		logic [31:0]      mag;
		logic             pixel_go;
		logic [DIM_W-1:0] col_next;
		logic [DIM_W-1:0] row_next;
		logic [DIM_W-1:0] row_flip;

		byte_offset_d = byte_offset_q;
		field_d       = field_q;
		data_start_d  = data_start_q;
		width_d       = width_q;
		height_d      = height_q;
		bottom_up_d   = bottom_up_q;
		col_cnt_d     = col_cnt_q;
		row_cnt_d     = row_cnt_q;
		pad_left_d    = pad_left_q;
		chan_d        = chan_q;
		bg_d          = bg_q;
		phase_d       = phase_q;
		if (first_byte_s1) begin
			byte_offset_d = '0;
			field_d       = '0;
			data_start_d  = '0;
			width_d       = '0;
			height_d      = '0;
			bottom_up_d   = 1'b0;
			col_cnt_d     = '0;
			row_cnt_d     = '0;
			pad_left_d    = '0;
			chan_d        = '0;
			bg_d          = '0;
			phase_d       = PH_HEADER;
		end

		emit     = 1'b0;
		res      = '0;
		pixel_go = 1'b0;
		v        = {file_byte_s1, field_d[31:8]};
		mag      = v[31] ? (32'd0 - v) : v;
		col_next = '0;
		row_next = '0;
		row_flip = '0;

		case (phase_d)
			PH_HEADER: begin
				field_d = v;
				case (byte_offset_d)
					POS_DATA_OFFSET: data_start_d = v;
					POS_HDR_SIZE: begin
						if (v < MIN_HEADER_SIZE) begin
							emit = 1'b1;
							res.status = ST_HDR_SMALL;
						end
					end
					POS_WIDTH: begin
						if (v[31] || v > 32'(MAX_WIDTH))
							width_d = WIDTH_OVER;
						else
							width_d = v[DIM_W-1:0];
					end
					POS_HEIGHT: begin
						bottom_up_d = (v != 32'd0) && !v[31];
						if (mag > 32'(MAX_HEIGHT))
							height_d = HEIGHT_OVER;
						else
							height_d = mag[DIM_W-1:0];
					end
					POS_PLANES: begin
						if (v[31:16] != 16'd1) begin
							emit = 1'b1;
							res.status = ST_BAD_PLANES;
						end
					end
					POS_BPP: begin
						emit = 1'b1;
						if (v[31:16] != PIXEL_BITS)
							res.status = ST_BAD_BPP;
						else if (height_d == '0)
							res.status = ST_ZERO_HGT;
						else if (width_d > DIM_W'(MAX_WIDTH) || height_d > DIM_W'(MAX_HEIGHT))
							res.status = ST_TOO_LARGE;
						else if (data_start_d < MIN_PIXEL_START)
							res.status = ST_BAD_OFFSET;
						else begin
							emit = 1'b0;
							phase_d = (width_d == '0) ? PH_DONE : PH_SKIP;
						end
					end
					default: ;
				endcase
				if (emit)
					phase_d = PH_DONE;
			end
			PH_SKIP: begin
				if (byte_offset_d >= data_start_d) begin
					phase_d  = PH_PIXELS;
					pixel_go = 1'b1;
				end
			end
			PH_PIXELS: pixel_go = 1'b1;
			default: ;
		endcase

		if (pixel_go) begin
			if (pad_left_d != 2'd0) begin
				pad_left_d = pad_left_d - 2'd1;
			end else if (chan_d == 2'd0) begin
				bg_d   = {8'd0, file_byte_s1};
				chan_d = 2'd1;
			end else if (chan_d == 2'd1) begin
				bg_d   = {file_byte_s1, bg_d[7:0]};
				chan_d = 2'd2;
			end else begin
				chan_d   = 2'd0;
				row_flip = height_d - DIM_W'(1) - DIM_W'(row_cnt_d);
				emit       = 1'b1;
				res.status = ST_PIXEL;
				res.red    = file_byte_s1;
				res.green  = bg_d[15:8];
				res.blue   = bg_d[7:0];
				res.column = col_cnt_d;
				res.row    = bottom_up_d ? row_flip[COORD_W-1:0] : row_cnt_d;
				col_next   = DIM_W'(col_cnt_d) + DIM_W'(1);
				if (col_next >= width_d) begin
					col_cnt_d = '0;
					row_next  = DIM_W'(row_cnt_d) + DIM_W'(1);
					row_cnt_d = row_next[COORD_W-1:0];
					// padding to a 4-byte row: (4 - 3w mod 4) mod 4 equals w mod 4
					pad_left_d = width_d[1:0];
					if (row_next >= height_d) begin
						res.last_pixel = 1'b1;
						phase_d = PH_DONE;
					end
				end else begin
					col_cnt_d = col_next[COORD_W-1:0];
				end
			end
		end

		if (byte_offset_d != 32'hFFFF_FFFF)
			byte_offset_d = byte_offset_d + 32'd1;
	end

	// handshake: room for the word in the input register once it reaches the queue
	assign pop      = out_valid && out_ready;
	assign push     = valid_s1 && emit;
	assign occ      = cnt_q + {1'b0, valid_s1};
	assign in_ready = (occ < 2'd2) || ((occ == 2'd2) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			file_byte_s1  <= file_byte;
			first_byte_s1 <= first_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			field_q       <= '0;
			data_start_q  <= '0;
			width_q       <= '0;
			height_q      <= '0;
			bottom_up_q   <= 1'b0;
			col_cnt_q     <= '0;
			row_cnt_q     <= '0;
			pad_left_q    <= '0;
			chan_q        <= '0;
			bg_q          <= '0;
			phase_q       <= PH_HEADER;
		end else if (valid_s1) begin
			byte_offset_q <= byte_offset_d;
			field_q       <= field_d;
			data_start_q  <= data_start_d;
			width_q       <= width_d;
			height_q      <= height_d;
			bottom_up_q   <= bottom_up_d;
			col_cnt_q     <= col_cnt_d;
			row_cnt_q     <= row_cnt_d;
			pad_left_q    <= pad_left_d;
			chan_q        <= chan_d;
			bg_q          <= bg_d;
			phase_q       <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= res;
	end

	assign out_valid  = (cnt_q != 2'd0);
	assign status     = entry_q[rd_ptr_q].status;
	assign red        = entry_q[rd_ptr_q].red;
	assign green      = entry_q[rd_ptr_q].green;
	assign blue       = entry_q[rd_ptr_q].blue;
	assign column     = entry_q[rd_ptr_q].column;
	assign row        = entry_q[rd_ptr_q].row;
	assign last_pixel = entry_q[rd_ptr_q].last_pixel;

endmodule
`default_nettype wire
